// File: hdl/atsr_pkg.sv
// shared types and constants of the accelerometer tilt, shake and roll detector
// used by atsr_div, atsr_pattern and the top level; no dependencies
`default_nettype none

package atsr_pkg;

  localparam int SampleBitsDef   = 10;
  localparam int PatternDepthDef = 8;

  // configuration port
  localparam int CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgXMin      = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgXMax      = 4'd1;
  localparam logic [CfgIdxW-1:0] CfgYMin      = 4'd2;
  localparam logic [CfgIdxW-1:0] CfgYMax      = 4'd3;
  localparam logic [CfgIdxW-1:0] CfgZMin      = 4'd4;
  localparam logic [CfgIdxW-1:0] CfgZMax      = 4'd5;
  localparam logic [CfgIdxW-1:0] CfgShakeLow  = 4'd6;
  localparam logic [CfgIdxW-1:0] CfgShakeHigh = 4'd7;

  // item fields
  localparam int AxisW  = 2;
  localparam int TimeW  = 32;
  localparam int TiltW  = 8;
  localparam int CodeW  = 2;
  localparam int NumAxes = 3;
  localparam logic [AxisW-1:0] AxisX    = 2'd0;
  localparam logic [AxisW-1:0] AxisY    = 2'd1;
  localparam logic [AxisW-1:0] AxisZ    = 2'd2;
  localparam logic [AxisW-1:0] AxisNone = 2'd3;
  localparam logic OpSample = 1'b0;
  localparam logic OpClear  = 1'b1;

  // tilt scaling: quotient of (v - min) * 250 / span never exceeds 250 while span is nonzero
  localparam int QuoW       = 8;
  localparam int TiltScale  = 250;
  localparam int TiltOffset = 127;
  localparam int TiltFire   = 96;
  localparam int TiltLevel  = 32;

  // moving average: x / 10 as x * 6554 >> 16, exact for x below 16384
  localparam int AvgRecip = 6554;
  localparam int AvgShift = 16;

  localparam int RollGapMs      = 2000;
  localparam int ShakeHoldMs    = 500;
  localparam int RollReadyMin   = 4;
  localparam int RollCodesShown = 8;
  localparam int RollCodesW     = 16;
  localparam int RollCountW     = 4;

  typedef enum logic [1:0] {
    TILT_LEVEL = 2'd0,
    TILT_POS   = 2'd1,
    TILT_NEG   = 2'd2
  } tilt_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_START,
    ST_DIV,
    ST_HYST,
    ST_AVG,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic [CodeW-1:0] code;
  } pat_cmd_t;

endpackage

`default_nettype wire

// File: hdl/accel_tilt_shake_roll_detector.sv
// Accelerometer tilt, shake and roll detector.
// Input channel (in_valid_i / in_stall_o): one beat carries op, axis, raw sample and a
// millisecond timestamp. An op-sample beat on axes x, y or z gives exactly one output beat
// (out_valid_o / out_stall_i) with scaled tilt, moving average, tilt and shake events and
// the roll pattern after this sample. A clear beat empties the pattern store and gives no
// output; a beat on axis code 3 is dropped.
// Steps: a sample runs clamp, start, 8 divider steps, the done flag, hysteresis, average
// and emit, and the output beat is loaded in the emit step. With the 8-step bit-serial
// divider in this chain, a new sample is accepted only after the last one leaves emit.
// in_stall_o is high while a sample is in work. A finished beat waits in the output
// register, and the next sample is accepted meanwhile; if the receiver still stalls when
// that sample finishes, it waits in the emit step.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and must only be written while
// the block is idle; indexes above 7 are ignored.
// Reset clears calibration to the full window, shake limits to the full range, averages
// and tilt states to level, the pattern store and both timestamps to zero.
`default_nettype none

module accel_tilt_shake_roll_detector #(
  parameter int SampleBits   = atsr_pkg::SampleBitsDef,
  parameter int PatternDepth = atsr_pkg::PatternDepthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [atsr_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [SampleBits-1:0]              cfg_data_i,
  // input items
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               op_i,
  input  wire logic [atsr_pkg::AxisW-1:0]         axis_i,
  input  wire logic [SampleBits-1:0]              raw_sample_i,
  input  wire logic [atsr_pkg::TimeW-1:0]         now_ms_i,
  // results
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [atsr_pkg::AxisW-1:0]              axis_out_o,
  output logic signed [atsr_pkg::TiltW-1:0]       scaled_tilt_o,
  output logic signed [atsr_pkg::TiltW-1:0]       averaged_tilt_o,
  output logic                                    tilt_event_o,
  output logic                                    tilt_positive_o,
  output logic                                    shake_event_o,
  output logic                                    roll_ready_o,
  output logic [atsr_pkg::RollCodesW-1:0]         roll_codes_o,
  output logic [atsr_pkg::RollCountW-1:0]         roll_count_o
);

  localparam int AxisW  = atsr_pkg::AxisW;
  localparam int TimeW  = atsr_pkg::TimeW;
  localparam int TiltW  = atsr_pkg::TiltW;
  localparam int QuoW   = atsr_pkg::QuoW;
  localparam int NAx    = atsr_pkg::NumAxes;
  localparam int CntW   = $clog2(PatternDepth + 1);
  localparam int SumW   = 12;
  localparam int SMagW  = 11;
  localparam int ProdW  = 24;
  localparam int MagW   = 7;

  // ---------------- configuration registers ----------------
  logic [SampleBits-1:0] cal_min_q [NAx];
  logic [SampleBits-1:0] cal_max_q [NAx];
  logic [SampleBits-1:0] shake_low_q, shake_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAx; i++) begin
        cal_min_q[i] <= '0;
        cal_max_q[i] <= '1;
      end
      shake_low_q  <= '0;
      shake_high_q <= '1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        atsr_pkg::CfgXMin:      cal_min_q[0] <= cfg_data_i;
        atsr_pkg::CfgXMax:      cal_max_q[0] <= cfg_data_i;
        atsr_pkg::CfgYMin:      cal_min_q[1] <= cfg_data_i;
        atsr_pkg::CfgYMax:      cal_max_q[1] <= cfg_data_i;
        atsr_pkg::CfgZMin:      cal_min_q[2] <= cfg_data_i;
        atsr_pkg::CfgZMax:      cal_max_q[2] <= cfg_data_i;
        atsr_pkg::CfgShakeLow:  shake_low_q  <= cfg_data_i;
        atsr_pkg::CfgShakeHigh: shake_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- control ----------------
  atsr_pkg::ctrl_state_e state_q, state_d;
  atsr_pkg::pat_cmd_t    pat_cmd;

  logic in_beat;
  logic take_sample;
  logic div_start;
  logic div_done;
  logic emit_load;

  logic                  out_valid_q;
  logic [QuoW-1:0]       div_quo;
  logic [atsr_pkg::RollCodesW-1:0] pat_codes;
  logic [CntW-1:0]       pat_count;

  // captured item
  logic [AxisW-1:0]      axis_q;
  logic [SampleBits-1:0] raw_q;
  logic [TimeW-1:0]      now_q;

  // work registers
  logic [SampleBits-1:0] diff_q, span_q;
  logic                  flat_q;
  logic signed [TiltW-1:0] tilt_q;
  logic                  sneg_q;
  logic [SMagW-1:0]      smag_q;
  logic                  tev_q, tpos_q, relevel_q, gap_q, sev_q;
  logic signed [TiltW-1:0] avg_new_q;

  // per-axis and timing state
  atsr_pkg::tilt_state_e tilt_status_q [NAx];
  logic signed [TiltW-1:0] axis_average_q [NAx];
  logic [TimeW-1:0]      last_roll_q, last_shake_q;

  assign in_beat = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    take_sample = 1'b0;
    div_start   = 1'b0;
    emit_load   = 1'b0;
    pat_cmd     = '0;
    pat_cmd.code = axis_q + AxisW'(1);
    unique case (state_q)
      atsr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (op_i == atsr_pkg::OpClear) begin
            pat_cmd.clear = 1'b1;
          end else if (axis_i != atsr_pkg::AxisNone) begin
            take_sample = 1'b1;
            state_d     = atsr_pkg::ST_CLAMP;
          end
        end
      end
      atsr_pkg::ST_CLAMP: state_d = atsr_pkg::ST_START;
      atsr_pkg::ST_START: begin
        div_start = 1'b1;
        state_d   = atsr_pkg::ST_DIV;
      end
      atsr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = atsr_pkg::ST_HYST;
        end
      end
      atsr_pkg::ST_HYST: state_d = atsr_pkg::ST_AVG;
      atsr_pkg::ST_AVG: begin
        // a tilt event after a long quiet gap starts a fresh pattern
        pat_cmd.push  = tev_q;
        pat_cmd.clear = tev_q && gap_q;
        state_d       = atsr_pkg::ST_EMIT;
      end
      atsr_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit_load = 1'b1;
          state_d   = atsr_pkg::ST_IDLE;
        end
      end
      default: state_d = atsr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atsr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------- clamp ----------------
  logic [SampleBits-1:0] lo, hi, clamped;
  always_comb begin
    lo = cal_min_q[axis_q];
    hi = cal_max_q[axis_q];
    if (raw_q > hi) begin
      clamped = hi;
    end else if (raw_q < lo) begin
      clamped = lo;
    end else begin
      clamped = raw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_sample) begin
      axis_q <= axis_i;
      raw_q  <= raw_sample_i;
      now_q  <= now_ms_i;
    end
    if (state_q == atsr_pkg::ST_CLAMP) begin
      flat_q <= hi <= lo;
      diff_q <= clamped - lo;
      span_q <= hi - lo;
    end
  end

  atsr_div #(
    .SampleBits(SampleBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .diff_i (diff_q),
    .span_i (span_q),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // ---------------- hysteresis, average sum, time windows ----------------
  logic signed [TiltW:0]    tilt_wide;
  logic signed [TiltW-1:0]  tilt;
  logic [MagW-1:0]          tmag;
  logic signed [SumW-1:0]   avg_x, tilt_x, sum;
  logic [SMagW-1:0]         smag;
  atsr_pkg::tilt_state_e    stat_cur;
  logic                     tev_d, relevel_d, gap_d, sev_d;
  logic [TimeW-1:0]         roll_dt, shake_dt;

  always_comb begin
    tilt_wide = $signed({1'b0, div_quo}) - $signed((TiltW + 1)'(atsr_pkg::TiltOffset));
    tilt      = flat_q ? TiltW'(-atsr_pkg::TiltOffset) : tilt_wide[TiltW-1:0];
    tmag      = tilt[TiltW-1] ? MagW'(-tilt) : MagW'(tilt);
    stat_cur  = tilt_status_q[axis_q];
    avg_x     = SumW'(axis_average_q[axis_q]);
    tilt_x    = SumW'(tilt);
    sum       = (avg_x <<< 3) + avg_x + tilt_x;
    smag      = sum[SumW-1] ? SMagW'(-sum) : SMagW'(sum);
    tev_d     = (tmag > MagW'(atsr_pkg::TiltFire)) && (stat_cur == atsr_pkg::TILT_LEVEL);
    relevel_d = (tmag < MagW'(atsr_pkg::TiltLevel)) && (stat_cur != atsr_pkg::TILT_LEVEL);
    roll_dt   = now_q - last_roll_q;
    shake_dt  = now_q - last_shake_q;
    gap_d     = roll_dt > TimeW'(atsr_pkg::RollGapMs);
    sev_d     = (shake_dt >= TimeW'(atsr_pkg::ShakeHoldMs))
                && ((raw_q < shake_low_q) || (raw_q > shake_high_q));
  end

  always_ff @(posedge clk_i) begin
    if (state_q == atsr_pkg::ST_HYST) begin
      tilt_q    <= tilt;
      sneg_q    <= sum[SumW-1];
      smag_q    <= smag;
      tev_q     <= tev_d;
      tpos_q    <= tev_d && !tilt[TiltW-1];
      relevel_q <= relevel_d;
      gap_q     <= gap_d;
      sev_q     <= sev_d;
    end
  end

  // ---------------- average divide by ten and state update ----------------
  logic [ProdW-1:0]       prod;
  logic [MagW-1:0]        qmag;
  logic signed [TiltW-1:0] avg_new;

  always_comb begin
    prod    = ProdW'(smag_q) * ProdW'(atsr_pkg::AvgRecip);
    qmag    = prod[atsr_pkg::AvgShift +: MagW];
    avg_new = sneg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAx; i++) begin
        tilt_status_q[i]  <= atsr_pkg::TILT_LEVEL;
        axis_average_q[i] <= '0;
      end
      last_roll_q  <= '0;
      last_shake_q <= '0;
    end else if (state_q == atsr_pkg::ST_AVG) begin
      axis_average_q[axis_q] <= avg_new;
      if (tev_q) begin
        tilt_status_q[axis_q] <= tpos_q ? atsr_pkg::TILT_POS : atsr_pkg::TILT_NEG;
        last_roll_q           <= now_q;
      end else if (relevel_q) begin
        tilt_status_q[axis_q] <= atsr_pkg::TILT_LEVEL;
      end
      if (sev_q) begin
        last_shake_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == atsr_pkg::ST_AVG) begin
      avg_new_q <= avg_new;
    end
  end

  atsr_pattern #(
    .PatternDepth(PatternDepth)
  ) u_pattern (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pat_cmd),
    .codes_o(pat_codes),
    .count_o(pat_count)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      axis_out_o      <= axis_q;
      scaled_tilt_o   <= tilt_q;
      averaged_tilt_o <= avg_new_q;
      tilt_event_o    <= tev_q;
      tilt_positive_o <= tpos_q;
      shake_event_o   <= sev_q;
      roll_ready_o    <= tev_q && (pat_count > CntW'(atsr_pkg::RollReadyMin));
      roll_codes_o    <= pat_codes;
      roll_count_o    <= atsr_pkg::RollCountW'(pat_count);
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_sample_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && op_i == atsr_pkg::OpSample && axis_i != atsr_pkg::AxisNone) |=> in_stall_o)
    else $error("sample beat accepted without going busy");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == atsr_pkg::ST_DIV)
    else $error("divider finished outside its wait step");

  a_ready_needs_tilt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (roll_ready_o || tilt_positive_o)) |-> tilt_event_o)
    else $error("roll ready or tilt direction without a tilt event");

  a_tilt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> scaled_tilt_o != TiltW'(8'h80) && averaged_tilt_o != TiltW'(8'h80))
    else $error("tilt value out of range");
`endif

endmodule

`default_nettype wire

// File: hdl/atsr_div.sv
// bit-serial restoring divider: (diff * 250) / span, one quotient bit per cycle
// uses atsr_pkg for the quotient width and the scale factor
`default_nettype none

module atsr_div #(
  parameter int SampleBits = atsr_pkg::SampleBitsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [SampleBits-1:0]       diff_i,
  input  wire logic [SampleBits-1:0]       span_i,
  output logic                             done_o,
  output logic [atsr_pkg::QuoW-1:0]        quo_o
);

  localparam int QuoW = atsr_pkg::QuoW;
  localparam int RemW = SampleBits + QuoW;
  localparam int CntW = $clog2(QuoW);

  logic [RemW-1:0] rem_q, rem_d;
  logic [RemW-1:0] dvs_q, dvs_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            fits;

  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    fits   = rem_q >= dvs_q;
    if (start_i) begin
      rem_d  = RemW'(diff_i) * RemW'(atsr_pkg::TiltScale);
      // divisor lined up with the top quotient bit
      dvs_d  = RemW'(span_i) << (QuoW - 1);
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - dvs_q;
      end
      quo_d = {quo_q[QuoW-2:0], fits};
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(QuoW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: hdl/atsr_pattern.sv
// roll pattern store: a shift line of axis codes, newest at entry 0, with a fill count
// uses atsr_pkg for the command struct and the output widths
`default_nettype none

module atsr_pattern #(
  parameter int PatternDepth = atsr_pkg::PatternDepthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire atsr_pkg::pat_cmd_t                cmd_i,
  output logic [atsr_pkg::RollCodesW-1:0]        codes_o,
  output logic [$clog2(PatternDepth+1)-1:0]      count_o
);

  localparam int CodeW = atsr_pkg::CodeW;
  localparam int CntW  = $clog2(PatternDepth + 1);

  logic [CodeW-1:0] store_q [PatternDepth];
  logic [CodeW-1:0] store_d [PatternDepth];
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    store_d = store_q;
    count_d = count_q;
    if (cmd_i.push) begin
      store_d[0] = cmd_i.code;
      for (int i = 1; i < PatternDepth; i++) begin
        store_d[i] = cmd_i.clear ? '0 : store_q[i-1];
      end
      if (cmd_i.clear) begin
        count_d = CntW'(1);
      end else if (count_q < CntW'(PatternDepth)) begin
        count_d = count_q + CntW'(1);
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < PatternDepth; i++) begin
        store_d[i] = '0;
      end
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PatternDepth; i++) begin
        store_q[i] <= '0;
      end
      count_q <= '0;
    end else begin
      store_q <= store_d;
      count_q <= count_d;
    end
  end

  for (genvar g = 0; g < atsr_pkg::RollCodesShown; g++) begin : g_codes
    if (g < PatternDepth) begin : g_held
      assign codes_o[g*CodeW +: CodeW] = store_q[g];
    end else begin : g_none
      assign codes_o[g*CodeW +: CodeW] = '0;
    end
  end

  assign count_o = count_q;

endmodule

`default_nettype wire
